// File: src/threshold_pixel_page_packer_top_macros.svh
// Assertion macros for the threshold pixel page packer
`ifndef THRESHOLD_PIXEL_PAGE_PACKER_TOP_MACROS_SVH
`define THRESHOLD_PIXEL_PAGE_PACKER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

`define TPPP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define TPPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define TPPP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)

`define TPPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: src/tppp_pkg.sv
// Shared types and constants for the threshold pixel page packer
package tppp_pkg;

	localparam int MAX_WIDTH_DEF = 128;
	localparam int STRIP_ROWS    = 8;
	localparam int OQ_DEPTH      = 3;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_COLUMN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_PAGE   = 3'd4;

	localparam logic [7:0] THRESHOLD_RST    = 8'd0;
	localparam logic [7:0] IMAGE_WIDTH_RST  = 8'd84;
	localparam logic [7:0] IMAGE_HEIGHT_RST = 8'd48;
	localparam logic [6:0] START_COLUMN_RST = 7'd0;
	localparam logic [2:0] START_PAGE_RST   = 3'd0;

	typedef struct packed {
		logic [7:0] page_byte;
		logic [7:0] page_addr;
		logic [7:0] column_addr;
		logic       frame_end;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		logic       full;
	} oq_status_t;

endpackage

// File: src/tppp_ifs.sv
// Channel interfaces: pixel input, page byte output, configuration writes
interface tppp_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel;
	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface tppp_page_if;
	logic       valid;
	logic       ready;
	logic [7:0] page_byte;
	logic [7:0] page_addr;
	logic [7:0] column_addr;
	logic       frame_end;
	modport source (output valid, output page_byte, output page_addr, output column_addr,
		output frame_end, input ready);
	modport sink (input valid, input page_byte, input page_addr, input column_addr,
		input frame_end, output ready);
endinterface

interface tppp_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [7:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/tppp_ram.sv
// Generic single-write, single-read RAM with registered read data
module tppp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/tppp_oq.sv
// Three-entry output queue for finished page bytes
module tppp_oq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  tppp_pkg::result_t    push_data,
	input  logic                 pop,
	output tppp_pkg::result_t    head,
	output logic                 head_valid,
	output tppp_pkg::oq_status_t status
);
	import tppp_pkg::*;

	result_t    entry_q [OQ_DEPTH];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [1:0] count_q;
	logic       do_pop;

	assign do_pop     = pop && (count_q != 2'd0);
	assign head       = entry_q[rd_ptr_q];
	assign head_valid = (count_q != 2'd0);
	assign status     = '{count: count_q, full: (count_q == 2'(OQ_DEPTH))};

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == 2'(OQ_DEPTH - 1)) ? 2'd0 : wr_ptr_q + 2'd1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == 2'(OQ_DEPTH - 1)) ? 2'd0 : rd_ptr_q + 2'd1;
			end
			count_q <= count_q + 2'(push) - 2'(do_pop);
		end
	end

endmodule

// File: src/threshold_pixel_page_packer_top.sv
// Top level: thresholds pixels and packs column bytes into display pages
// A page byte is registered in stage 1 and then in the output queue before it is offered.
// Throughput: 1 pixel per clock while the output keeps up; the column store is read one
// cycle and written back the next, with the last write forwarded to a following read.
// Reset returns configuration to its defaults and clears counters and the output queue;
// the column store is not cleared, each strip's first row overwrites it.
`include "threshold_pixel_page_packer_top_macros.svh"

module threshold_pixel_page_packer_top #(
	parameter int MAX_WIDTH = tppp_pkg::MAX_WIDTH_DEF
) (
	input logic      clk,
	input logic      arst_n,
	tppp_pixel_if.sink   pixels,
	tppp_page_if.source  pages,
	tppp_cfg_if.sink     cfg
);
	import tppp_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	logic [7:0] threshold_q;
	logic [7:0] image_width_q;
	logic [7:0] image_height_q;
	logic [6:0] start_column_q;
	logic [2:0] start_page_q;

	logic [CW-1:0] col_q;
	logic [7:0]    row_q;

	logic          valid_s1;
	logic [CW-1:0] col_s1;
	logic [2:0]    k_s1;
	logic          bit_s1;
	logic          emit_s1;
	logic [7:0]    page_s1;
	logic [7:0]    column_s1;
	logic          frame_end_s1;

	logic          fwd_v_q;
	logic [CW-1:0] fwd_col_q;
	logic [7:0]    fwd_data_q;

	logic          in_acc;
	logic [8:0]    eff_w;
	logic [8:0]    eff_h;
	logic          last_col;
	logic          last_row;
	logic [2:0]    k;
	logic [7:0]    rd_data;
	logic [7:0]    old_byte;
	logic [7:0]    new_byte;
	logic          pix_bit;
	result_t       res;
	result_t       head;
	oq_status_t    oq_st;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q    <= THRESHOLD_RST;
			image_width_q  <= IMAGE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
			start_column_q <= START_COLUMN_RST;
			start_page_q   <= START_PAGE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_THRESHOLD:    threshold_q    <= cfg.data;
				REG_IMAGE_WIDTH:  image_width_q  <= cfg.data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg.data;
				REG_START_COLUMN: start_column_q <= cfg.data[6:0];
				REG_START_PAGE:   start_page_q   <= cfg.data[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		eff_w = (image_width_q == 8'd0) ? 9'd1 : {1'b0, image_width_q};
		if (eff_w > 9'(MAX_WIDTH)) begin
			eff_w = 9'(MAX_WIDTH);
		end
		eff_h = (image_height_q == 8'd0) ? 9'd1 : {1'b0, image_height_q};
	end

	assign in_acc       = pixels.valid && pixels.ready;
	assign pixels.ready = (({1'b0, oq_st.count} + {2'b00, valid_s1}) <= 3'd2);
	assign last_col     = (9'(col_q) + 9'd1 >= eff_w);
	assign last_row     = ({1'b0, row_q} + 9'd1 >= eff_h);
	assign k            = row_q[2:0];
	assign pix_bit      = !(pixels.pixel > threshold_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
			fwd_v_q  <= 1'b0;
		end else begin
			valid_s1 <= in_acc;
			fwd_v_q  <= valid_s1;
			if (in_acc) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? 8'd0 : row_q + 8'd1;
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			col_s1       <= col_q;
			k_s1         <= k;
			bit_s1       <= pix_bit;
			emit_s1      <= (k == 3'(STRIP_ROWS - 1)) || last_row;
			page_s1      <= 8'(start_page_q) + 8'(row_q >> 3);
			column_s1    <= 8'(9'(start_column_q) + 9'(col_q));
			frame_end_s1 <= last_row && last_col;
		end
		if (valid_s1) begin
			fwd_col_q  <= col_s1;
			fwd_data_q <= new_byte;
		end
	end

	tppp_ram #(
		.WIDTH (8),
		.DEPTH (MAX_WIDTH)
	) u_col_ram (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1),
		.wdata (new_byte),
		.raddr (col_q),
		.rdata (rd_data)
	);

	always_comb begin
		old_byte = (fwd_v_q && (fwd_col_q == col_s1)) ? fwd_data_q : rd_data;
		if (k_s1 == 3'd0) begin
			new_byte = {7'd0, bit_s1};
		end else begin
			new_byte = (old_byte & ~(8'd1 << k_s1)) | ({7'd0, bit_s1} << k_s1);
		end
	end

	assign res = '{page_byte: new_byte, page_addr: page_s1, column_addr: column_s1,
		frame_end: frame_end_s1};

	tppp_oq u_oq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (valid_s1 && emit_s1),
		.push_data  (res),
		.pop        (pages.ready),
		.head       (head),
		.head_valid (pages.valid),
		.status     (oq_st)
	);

	assign pages.page_byte   = head.page_byte;
	assign pages.page_addr   = head.page_addr;
	assign pages.column_addr = head.column_addr;
	assign pages.frame_end   = head.frame_end;

	`TPPP_ASSERT_SAME(a_no_overflow, clk, arst_n, valid_s1 && emit_s1 && oq_st.full, pages.ready, "output queue overflow")
	`TPPP_ASSERT_NEXT(a_acc_to_s1, clk, arst_n, in_acc, valid_s1, "accepted pixel missing from stage 1")
	`TPPP_ASSERT_SAME(a_stall_cause, clk, arst_n, !pixels.ready, oq_st.count != 2'd0, "input stalled with empty queue")

endmodule
